@@ hdl/nnlu_pkg.sv @@
// Shared constants, codes and controller/datapath interface types for the neighbour list unit.
`timescale 1ns / 1ps

package nnlu_pkg;

	localparam int MAX_NODES_DEF      = 64;
	localparam int MAX_NEIGHBOURS_DEF = 8;
	localparam int DIST_BITS_DEF      = 16;

	localparam int ACT_W      = 2;
	localparam int NODE_IN_W  = 6;
	localparam int DIST_IN_W  = 16;
	localparam int CHG_W      = 6;
	localparam int NC_W       = 4;
	localparam int VC_W       = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [NC_W-1:0] NEIGHBOUR_COUNT_RST = 4'd8;
	localparam logic [VC_W-1:0] NODE_COUNT_RST      = 7'd64;

	localparam logic [CFG_IDX_W-1:0] CFG_NEIGHBOUR_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT      = 2'd1;

	typedef enum logic [ACT_W-1:0] {
		ACT_WRITE  = 2'd0,
		ACT_INSERT = 2'd1,
		ACT_QUERY  = 2'd2,
		ACT_CLEAR  = 2'd3
	} action_t;

	typedef struct packed {
		logic load;
		logic dist_wr;
		logic clr_wr;
		logic nb_rd;
		logic qry_sel;
		logic place;
		logic scan_start;
		logic scan;
		logic row_inc;
		logic member_set;
	} nnlu_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic fresh_out;
		logic row_skip;
		logic row_last;
		logic has_empty;
		logic scan_done;
	} nnlu_sts_t;

endpackage

@@ hdl/nnlu_ctrl.sv @@
// Controller state machine that sequences requests through the neighbour list datapath.
`timescale 1ns / 1ps

module nnlu_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  nnlu_pkg::action_t   action,
	input  nnlu_pkg::nnlu_sts_t sts,
	output nnlu_pkg::nnlu_cmd_t cmd,
	output logic                busy,
	output logic                done
);

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_DWR,
		S_INS,
		S_ROW,
		S_CHK,
		S_SCAN,
		S_NEXT,
		S_QRD,
		S_QCHK,
		S_CLR,
		S_DONE
	} state_t;

	state_t state_q, state_d;
	logic   busy_q, busy_d;
	logic   done_q, done_d;

	always_comb begin
		state_d = state_q;
		busy_d  = busy_q;
		done_d  = 1'b0;
		cmd     = '0;
		case (state_q)
			S_INIT: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
					busy_d  = 1'b0;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					busy_d   = 1'b1;
					case (action)
						nnlu_pkg::ACT_WRITE:  state_d = S_DWR;
						nnlu_pkg::ACT_INSERT: state_d = S_INS;
						nnlu_pkg::ACT_QUERY:  state_d = S_QRD;
						nnlu_pkg::ACT_CLEAR:  state_d = S_CLR;
						default: begin
							state_d = S_DONE;
							done_d  = 1'b1;
						end
					endcase
				end
			end
			S_DWR: begin
				cmd.dist_wr = 1'b1;
				state_d     = S_DONE;
				done_d      = 1'b1;
			end
			S_INS: begin
				if (sts.fresh_out) begin
					state_d = S_DONE;
					done_d  = 1'b1;
				end else begin
					state_d = S_ROW;
				end
			end
			S_ROW: begin
				if (sts.row_skip) begin
					if (sts.row_last) begin
						state_d = S_DONE;
						done_d  = 1'b1;
					end else begin
						cmd.row_inc = 1'b1;
					end
				end else begin
					cmd.nb_rd = 1'b1;
					state_d   = S_CHK;
				end
			end
			S_CHK: begin
				if (sts.has_empty) begin
					cmd.place = 1'b1;
					state_d   = S_NEXT;
				end else begin
					cmd.scan_start = 1'b1;
					state_d        = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) begin
					state_d = S_NEXT;
				end
			end
			S_NEXT: begin
				if (sts.row_last) begin
					state_d = S_DONE;
					done_d  = 1'b1;
				end else begin
					cmd.row_inc = 1'b1;
					state_d     = S_ROW;
				end
			end
			S_QRD: begin
				cmd.nb_rd   = 1'b1;
				cmd.qry_sel = 1'b1;
				state_d     = S_QCHK;
			end
			S_QCHK: begin
				cmd.member_set = 1'b1;
				state_d        = S_DONE;
				done_d         = 1'b1;
			end
			S_CLR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_d = S_DONE;
					done_d  = 1'b1;
				end
			end
			S_DONE: begin
				busy_d  = 1'b0;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
				busy_d  = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			busy_q  <= 1'b1;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			busy_q  <= busy_d;
			done_q  <= done_d;
		end
	end

	assign busy = busy_q;
	assign done = done_q;

endmodule

@@ hdl/nnlu_dpath.sv @@
// Datapath with distance memory, neighbour list memory, row walker and farthest-slot scan.
`timescale 1ns / 1ps

module nnlu_dpath #(
	parameter int MAX_NODES      = nnlu_pkg::MAX_NODES_DEF,
	parameter int MAX_NEIGHBOURS = nnlu_pkg::MAX_NEIGHBOURS_DEF,
	parameter int DIST_BITS      = nnlu_pkg::DIST_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  nnlu_pkg::nnlu_cmd_t                 cmd,
	output nnlu_pkg::nnlu_sts_t                 sts,
	input  logic [nnlu_pkg::NODE_IN_W-1:0]      row_node,
	input  logic [nnlu_pkg::NODE_IN_W-1:0]      col_node,
	input  logic [nnlu_pkg::DIST_IN_W-1:0]      distance,
	input  logic                                cfg_we,
	input  logic [nnlu_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [nnlu_pkg::CFG_DATA_W-1:0]     cfg_data,
	output logic                                is_member,
	output logic [nnlu_pkg::CHG_W-1:0]          rows_changed
);

	localparam int NODE_W  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int RC_W    = $clog2(MAX_NODES + 1);
	localparam int SLOT_W  = (MAX_NEIGHBOURS > 1) ? $clog2(MAX_NEIGHBOURS) : 1;
	localparam int PC_W    = $clog2(MAX_NEIGHBOURS + 1);
	localparam int ENTRY_W = NODE_W + 1;
	localparam int ROW_W   = MAX_NEIGHBOURS * ENTRY_W;
	localparam int DDEPTH  = MAX_NODES * MAX_NODES;
	localparam int DA_W    = $clog2(DDEPTH);

	logic [nnlu_pkg::NC_W-1:0]      nc_q;
	logic [nnlu_pkg::VC_W-1:0]      vc_q;
	logic [nnlu_pkg::NODE_IN_W-1:0] row_q;
	logic [nnlu_pkg::NODE_IN_W-1:0] col_q;
	logic [DIST_BITS-1:0]           dist_q;
	logic [NODE_W-1:0]              r_q;
	logic [nnlu_pkg::CHG_W-1:0]     changed_q;
	logic                           member_q;

	logic [DIST_BITS-1:0] dist_mem [DDEPTH];
	logic [DIST_BITS-1:0] dist_rd_q;
	logic [ROW_W-1:0]     nb_mem [MAX_NODES];
	logic [ROW_W-1:0]     nb_rd_q;

	logic                 scan_act_q;
	logic [PC_W-1:0]      k_q;
	logic                 scan_vld_s1;
	logic [PC_W-1:0]      scan_k_s1;
	logic                 have_far_q;
	logic [DIST_BITS-1:0] far_q;
	logic [SLOT_W-1:0]    far_slot_q;

	logic [PC_W-1:0]   p_used;
	logic [RC_W-1:0]   v_used;
	logic [NODE_W-1:0] fresh;
	logic              rd_vld  [MAX_NEIGHBOURS];
	logic [NODE_W-1:0] rd_node [MAX_NEIGHBOURS];
	logic              empty_found;
	logic [SLOT_W-1:0] empty_slot;
	logic              hit;
	logic [SLOT_W-1:0] wr_slot;
	logic [ROW_W-1:0]  nb_wdata;
	logic              nb_we;
	logic [NODE_W-1:0] nb_raddr;
	logic              scan_issue;
	logic [NODE_W-1:0] scan_col;
	logic              scan_done;
	logic              replace;
	logic              dist_we;
	logic [DA_W-1:0]   dist_waddr;
	logic [DA_W-1:0]   dist_raddr;

	always_comb begin
		if (nc_q == '0) begin
			p_used = PC_W'(1);
		end else if (32'(nc_q) > MAX_NEIGHBOURS) begin
			p_used = PC_W'(MAX_NEIGHBOURS);
		end else begin
			p_used = PC_W'(nc_q);
		end
		if (vc_q == '0) begin
			v_used = RC_W'(1);
		end else if (32'(vc_q) > MAX_NODES) begin
			v_used = RC_W'(MAX_NODES);
		end else begin
			v_used = RC_W'(vc_q);
		end
	end

	assign fresh = NODE_W'(row_q);

	always_comb begin
		for (int s = 0; s < MAX_NEIGHBOURS; s++) begin
			rd_vld[s]  = nb_rd_q[s*ENTRY_W + NODE_W];
			rd_node[s] = nb_rd_q[s*ENTRY_W +: NODE_W];
		end
	end

	always_comb begin
		empty_found = 1'b0;
		empty_slot  = '0;
		hit         = 1'b0;
		for (int s = 0; s < MAX_NEIGHBOURS; s++) begin
			if (!empty_found && (s < 32'(p_used)) && !rd_vld[s]) begin
				empty_found = 1'b1;
				empty_slot  = SLOT_W'(s);
			end
			if ((s < 32'(p_used)) && rd_vld[s] && (32'(rd_node[s]) == 32'(col_q))) begin
				hit = 1'b1;
			end
		end
	end

	assign wr_slot = cmd.place ? empty_slot : far_slot_q;

	always_comb begin
		nb_wdata = '0;
		if (!cmd.clr_wr) begin
			for (int s = 0; s < MAX_NEIGHBOURS; s++) begin
				if (SLOT_W'(s) == wr_slot) begin
					nb_wdata[s*ENTRY_W +: ENTRY_W] = {1'b1, fresh};
				end else begin
					nb_wdata[s*ENTRY_W +: ENTRY_W] = {rd_vld[s], rd_node[s]};
				end
			end
		end
	end

	assign scan_done = cmd.scan && scan_vld_s1 && (scan_k_s1 == p_used);
	assign replace   = dist_rd_q < far_q;
	assign nb_we     = cmd.clr_wr || cmd.place || (scan_done && replace);
	assign nb_raddr  = cmd.qry_sel ? NODE_W'(row_q) : r_q;

	always_ff @(posedge clk) begin
		if (nb_we) begin
			nb_mem[r_q] <= nb_wdata;
		end
		if (cmd.nb_rd) begin
			nb_rd_q <= nb_mem[nb_raddr];
		end
	end

	assign scan_issue = cmd.scan && scan_act_q;
	assign scan_col   = (k_q == p_used) ? fresh : rd_node[k_q[SLOT_W-1:0]];
	assign dist_raddr = DA_W'(r_q) * DA_W'(MAX_NODES) + DA_W'(scan_col);
	assign dist_waddr = DA_W'(NODE_W'(row_q)) * DA_W'(MAX_NODES) + DA_W'(NODE_W'(col_q));
	assign dist_we    = cmd.dist_wr && (32'(row_q) < MAX_NODES) && (32'(col_q) < MAX_NODES);

	always_ff @(posedge clk) begin
		if (dist_we) begin
			dist_mem[dist_waddr] <= dist_q;
		end
		if (scan_issue) begin
			dist_rd_q <= dist_mem[dist_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			row_q  <= row_node;
			col_q  <= col_node;
			dist_q <= DIST_BITS'(distance);
		end
		if (scan_issue) begin
			scan_k_s1 <= k_q;
		end
		if (cmd.scan_start) begin
			have_far_q <= 1'b0;
		end else if (cmd.scan && scan_vld_s1 && (scan_k_s1 != p_used)) begin
			if (!have_far_q || (dist_rd_q > far_q)) begin
				have_far_q <= 1'b1;
				far_q      <= dist_rd_q;
				far_slot_q <= scan_k_s1[SLOT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nc_q        <= nnlu_pkg::NEIGHBOUR_COUNT_RST;
			vc_q        <= nnlu_pkg::NODE_COUNT_RST;
			r_q         <= '0;
			changed_q   <= '0;
			member_q    <= 1'b0;
			scan_act_q  <= 1'b0;
			k_q         <= '0;
			scan_vld_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					nnlu_pkg::CFG_NEIGHBOUR_COUNT: nc_q <= cfg_data[nnlu_pkg::NC_W-1:0];
					nnlu_pkg::CFG_NODE_COUNT:      vc_q <= cfg_data[nnlu_pkg::VC_W-1:0];
					default: ;
				endcase
			end
			if (cmd.load) begin
				r_q       <= '0;
				changed_q <= '0;
				member_q  <= 1'b0;
			end else if (cmd.clr_wr || cmd.row_inc) begin
				r_q <= r_q + NODE_W'(1);
			end
			if (cmd.place || (scan_done && replace)) begin
				changed_q <= changed_q + nnlu_pkg::CHG_W'(1);
			end
			if (cmd.member_set) begin
				member_q <= hit && (32'(row_q) < MAX_NODES);
			end
			if (cmd.scan_start) begin
				scan_act_q <= 1'b1;
				k_q        <= '0;
			end else if (scan_issue) begin
				k_q <= k_q + PC_W'(1);
				if (k_q == p_used) begin
					scan_act_q <= 1'b0;
				end
			end
			scan_vld_s1 <= scan_issue;
		end
	end

	assign sts.clr_last  = (r_q == NODE_W'(MAX_NODES - 1));
	assign sts.fresh_out = (32'(row_q) >= 32'(v_used));
	assign sts.row_skip  = (32'(r_q) == 32'(row_q));
	assign sts.row_last  = (32'(r_q) == (32'(v_used) - 1));
	assign sts.has_empty = empty_found;
	assign sts.scan_done = scan_done;

	assign is_member    = member_q;
	assign rows_changed = changed_q;

endmodule

@@ hdl/nearest_neighbour_list_update_unit.sv @@
// Top level of the nearest neighbour list update unit: controller, datapath and checks.
`timescale 1ns / 1ps

// Channel        Signals                                        Transfer
// request        start, busy, action, row_node, col_node,       start high, busy low
//                distance
// result         done, is_member, rows_changed                  done high for one cycle
// configuration  cfg_valid, cfg_ready, cfg_index, cfg_data      cfg_valid and cfg_ready high
//
// One request is worked on at a time; busy stays high until its result has been shown.
// A clear empties the neighbour memory row by row. An insert walks the rows in use: it
// skips the inserted node's own row, puts the node into the first empty slot of a row,
// or else scans the p slots in use and the new node for the farthest entry; the distance
// memory read port, one read a cycle, sets the pace of the farthest-slot scan.
// After reset the neighbour memory is cleared row by row with busy high.
// Results cannot be held off: done marks the result; is_member and rows_changed hold until the next request.

module nearest_neighbour_list_update_unit #(
	parameter int MAX_NODES      = nnlu_pkg::MAX_NODES_DEF,
	parameter int MAX_NEIGHBOURS = nnlu_pkg::MAX_NEIGHBOURS_DEF,
	parameter int DIST_BITS      = nnlu_pkg::DIST_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [nnlu_pkg::ACT_W-1:0]      action,
	input  logic [nnlu_pkg::NODE_IN_W-1:0]  row_node,
	input  logic [nnlu_pkg::NODE_IN_W-1:0]  col_node,
	input  logic [nnlu_pkg::DIST_IN_W-1:0]  distance,
	output logic                            done,
	output logic                            is_member,
	output logic [nnlu_pkg::CHG_W-1:0]      rows_changed,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [nnlu_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [nnlu_pkg::CFG_DATA_W-1:0] cfg_data
);

	nnlu_pkg::nnlu_cmd_t cmd;
	nnlu_pkg::nnlu_sts_t sts;
	logic                accept;

	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	nnlu_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.action (nnlu_pkg::action_t'(action)),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	nnlu_dpath #(
		.MAX_NODES      (MAX_NODES),
		.MAX_NEIGHBOURS (MAX_NEIGHBOURS),
		.DIST_BITS      (DIST_BITS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.row_node     (row_node),
		.col_node     (col_node),
		.distance     (distance),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.is_member    (is_member),
		.rows_changed (rows_changed)
	);

	a_done_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result shown while no request is in progress");

	a_accept_sets_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("busy did not rise after a request was taken");

	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe lasted more than one cycle");

	a_member_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		(done && is_member) |-> (rows_changed == '0))
		else $error("query result also reports changed lists");

endmodule

@@ bench/testbench.sv @@
// Self-checking testbench for the nearest neighbour list update unit, with a predictor of its lists.
`timescale 1ns / 1ps

module testbench;
	import nnlu_pkg::*;

	localparam int NODES        = MAX_NODES_DEF;
	localparam int SLOTS        = MAX_NEIGHBOURS_DEF;
	localparam int ITEM_TARGET  = 900;
	localparam int QUIET_ITEMS  = 120;
	localparam int DRAIN_CYCLES = 60;
	localparam int unsigned CYCLE_LIMIT = 5_000_000;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

	typedef struct packed {
		logic              member;
		logic [CHG_W-1:0]  changed;
	} response_t;

	typedef struct packed {
		action_t               act;
		logic [NODE_IN_W-1:0]  row;
		logic [NODE_IN_W-1:0]  col;
		logic [DIST_IN_W-1:0]  span;
		logic                  fixed;
		response_t             resp;
	} directed_t;

	localparam response_t R_ZERO  = '{1'b0, 6'd0};
	localparam response_t R_HIT   = '{1'b1, 6'd0};
	localparam response_t R_THREE = '{1'b0, 6'd3};

	localparam logic [CFG_DATA_W-1:0] PHASE_NC [6] = '{8'h01, 8'h08, 8'h00, 8'hFF, 8'h09, 8'h03};
	localparam logic [CFG_DATA_W-1:0] PHASE_VC [6] = '{8'h02, 8'h40, 8'h00, 8'hFF, 8'h41, 8'h06};

	// Runs with four nodes and two slots per list.
	directed_t directed_steps [27] = '{
		'{ACT_QUERY,  6'd0,  6'd0,  16'd0,     1'b1, R_ZERO},
		'{ACT_QUERY,  6'd63, 6'd63, 16'd0,     1'b1, R_ZERO},
		'{ACT_WRITE,  6'd1,  6'd0,  16'd0,     1'b1, R_ZERO},
		'{ACT_WRITE,  6'd2,  6'd0,  16'hFFFF,  1'b1, R_ZERO},
		'{ACT_WRITE,  6'd3,  6'd0,  16'd100,   1'b1, R_ZERO},
		'{ACT_INSERT, 6'd63, 6'd0,  16'd0,     1'b1, R_ZERO},
		'{ACT_INSERT, 6'd4,  6'd0,  16'd0,     1'b1, R_ZERO},
		'{ACT_INSERT, 6'd0,  6'd0,  16'd0,     1'b1, R_THREE},
		'{ACT_QUERY,  6'd1,  6'd0,  16'd0,     1'b1, R_HIT},
		'{ACT_QUERY,  6'd0,  6'd1,  16'd0,     1'b1, R_ZERO},
		'{ACT_WRITE,  6'd0,  6'd1,  16'd5,     1'b1, R_ZERO},
		'{ACT_WRITE,  6'd2,  6'd1,  16'd7,     1'b1, R_ZERO},
		'{ACT_WRITE,  6'd3,  6'd1,  16'd200,   1'b1, R_ZERO},
		'{ACT_INSERT, 6'd1,  6'd0,  16'd0,     1'b1, R_THREE},
		'{ACT_WRITE,  6'd0,  6'd2,  16'd9,     1'b1, R_ZERO},
		'{ACT_WRITE,  6'd1,  6'd2,  16'd3,     1'b1, R_ZERO},
		'{ACT_WRITE,  6'd3,  6'd2,  16'd50,    1'b1, R_ZERO},
		'{ACT_INSERT, 6'd2,  6'd0,  16'd0,     1'b0, R_ZERO},
		'{ACT_WRITE,  6'd0,  6'd3,  16'hFFFF,  1'b1, R_ZERO},
		'{ACT_WRITE,  6'd1,  6'd3,  16'd0,     1'b1, R_ZERO},
		'{ACT_WRITE,  6'd2,  6'd3,  16'hFFFF,  1'b1, R_ZERO},
		'{ACT_INSERT, 6'd3,  6'd0,  16'd0,     1'b0, R_ZERO},
		'{ACT_QUERY,  6'd3,  6'd0,  16'd0,     1'b0, R_ZERO},
		'{ACT_QUERY,  6'd2,  6'd3,  16'd0,     1'b0, R_ZERO},
		'{ACT_CLEAR,  6'd63, 6'd63, 16'hFFFF,  1'b1, R_ZERO},
		'{ACT_QUERY,  6'd1,  6'd0,  16'd0,     1'b1, R_ZERO},
		'{ACT_INSERT, 6'd3,  6'd0,  16'd0,     1'b1, R_THREE}
	};

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic [ACT_W-1:0]      action;
	logic [NODE_IN_W-1:0]  row_node;
	logic [NODE_IN_W-1:0]  col_node;
	logic [DIST_IN_W-1:0]  distance;
	logic                  done;
	logic                  is_member;
	logic [CHG_W-1:0]      rows_changed;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	bit [DIST_IN_W-1:0] dist_matrix [NODES][NODES];
	bit                 dist_written [NODES][NODES];
	bit [NODE_IN_W-1:0] list_node [NODES][SLOTS];
	bit                 list_used [NODES][SLOTS];
	bit [NC_W-1:0]      slot_setting;
	bit [VC_W-1:0]      node_setting;

	response_t   expected_results [$];
	int          errors = 0;
	int          items_sent = 0;
	bit          gaps_on;
	int unsigned cycle_count = 0;

	nearest_neighbour_list_update_unit i_dut (.*);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int slots_in_use();
		if (slot_setting == 0) return 1;
		if (slot_setting > SLOTS) return SLOTS;
		return int'(slot_setting);
	endfunction

	function automatic int nodes_in_use();
		if (node_setting == 0) return 1;
		if (node_setting > NODES) return NODES;
		return int'(node_setting);
	endfunction

	function automatic int insert_into_lists(int fresh);
		int v;
		int p;
		int changed;
		int far_slot;
		bit [DIST_IN_W-1:0] far_dist;
		bit [DIST_IN_W-1:0] d;
		bit placed;
		bit have_far;
		v = nodes_in_use();
		p = slots_in_use();
		changed = 0;
		if (fresh >= v) return 0;
		for (int r = 0; r < v; r++) begin
			if (r == fresh) continue;
			placed = 1'b0;
			have_far = 1'b0;
			far_dist = '0;
			far_slot = 0;
			for (int s = 0; s < p; s++) begin
				if (!list_used[r][s]) begin
					list_used[r][s] = 1'b1;
					list_node[r][s] = NODE_IN_W'(fresh);
					placed = 1'b1;
					break;
				end
				d = dist_matrix[r][list_node[r][s]];
				if (!have_far || d > far_dist) begin
					have_far = 1'b1;
					far_dist = d;
					far_slot = s;
				end
			end
			if (!placed && have_far && dist_matrix[r][fresh] < far_dist) begin
				list_node[r][far_slot] = NODE_IN_W'(fresh);
				placed = 1'b1;
			end
			if (placed) changed++;
		end
		return changed;
	endfunction

	function automatic bit list_holds(int row, int cand);
		for (int s = 0; s < slots_in_use(); s++) begin
			if (list_used[row][s] && list_node[row][s] == cand) return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic response_t predict_response(action_t act, int row, int col,
			bit [DIST_IN_W-1:0] span);
		response_t resp;
		resp = R_ZERO;
		case (act)
			ACT_WRITE: begin
				dist_matrix[row][col] = span;
				dist_written[row][col] = 1'b1;
			end
			ACT_INSERT: begin
				resp.changed = CHG_W'(insert_into_lists(row));
			end
			ACT_QUERY: begin
				resp.member = list_holds(row, col);
			end
			default: begin
				for (int r = 0; r < NODES; r++) begin
					for (int s = 0; s < SLOTS; s++) begin
						list_used[r][s] = 1'b0;
						list_node[r][s] = '0;
					end
				end
			end
		endcase
		return resp;
	endfunction

	function automatic logic [DIST_IN_W-1:0] random_distance();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3: return DIST_IN_W'($urandom);
			default: return DIST_IN_W'($urandom_range(0, 7));
		endcase
	endfunction

	task automatic send_request(action_t act, logic [NODE_IN_W-1:0] row,
			logic [NODE_IN_W-1:0] col, logic [DIST_IN_W-1:0] span, bit fixed,
			response_t fixed_resp);
		response_t predicted;
		@(negedge clk);
		if (gaps_on && (items_sent < ITEM_TARGET - QUIET_ITEMS) && $urandom_range(0, 3) == 0) begin
			start = 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		start = 1'b1;
		action = act;
		row_node = row;
		col_node = col;
		distance = span;
		do @(posedge clk); while (busy);
		predicted = predict_response(act, row, col, span);
		expected_results = {expected_results, (fixed ? fixed_resp : predicted)};
		items_sent++;
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		start = 1'b0;
		while (expected_results.size() != 0 || busy) @(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_NEIGHBOUR_COUNT) slot_setting = data[NC_W-1:0];
		else if (idx == CFG_NODE_COUNT) node_setting = data[VC_W-1:0];
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// An insert may read the distance to every listed node and to the new node, so
	// any such entry not yet loaded is written first.
	task automatic fill_unwritten_distances(int fresh);
		int v;
		int p;
		v = nodes_in_use();
		p = slots_in_use();
		if (fresh >= v) return;
		for (int r = 0; r < v; r++) begin
			if (r == fresh) continue;
			for (int s = 0; s < p; s++) begin
				if (list_used[r][s] && !dist_written[r][list_node[r][s]])
					send_request(ACT_WRITE, NODE_IN_W'(r), list_node[r][s],
						random_distance(), 1'b0, R_ZERO);
			end
			if (!dist_written[r][fresh])
				send_request(ACT_WRITE, NODE_IN_W'(r), NODE_IN_W'(fresh),
					random_distance(), 1'b0, R_ZERO);
		end
	endtask

	task automatic random_item();
		int v;
		int pick;
		int row;
		int col;
		v = nodes_in_use();
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			row = ($urandom_range(0, 9) == 0) ? $urandom_range(0, NODES - 1)
				: $urandom_range(0, (v < 10 ? v : 10) - 1);
			fill_unwritten_distances(row);
			send_request(ACT_INSERT, NODE_IN_W'(row), NODE_IN_W'($urandom),
				DIST_IN_W'($urandom), 1'b0, R_ZERO);
		end else if (pick < 80) begin
			row = ($urandom_range(0, 9) == 0) ? $urandom_range(0, NODES - 1)
				: $urandom_range(0, v - 1);
			col = $urandom_range(0, 1) ? int'(list_node[row][$urandom_range(0, SLOTS - 1)])
				: $urandom_range(0, NODES - 1);
			send_request(ACT_QUERY, NODE_IN_W'(row), NODE_IN_W'(col),
				DIST_IN_W'($urandom), 1'b0, R_ZERO);
		end else if (pick < 96) begin
			send_request(ACT_WRITE, NODE_IN_W'($urandom), NODE_IN_W'($urandom),
				random_distance(), 1'b0, R_ZERO);
		end else begin
			send_request(ACT_CLEAR, NODE_IN_W'($urandom), NODE_IN_W'($urandom),
				DIST_IN_W'($urandom), 1'b0, R_ZERO);
		end
	endtask

	always @(posedge clk) begin
		response_t want;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				errors++;
				$error("unexpected result: is_member %0d, rows_changed %0d",
					is_member, rows_changed);
			end else begin
				want = expected_results.pop_front();
				if (is_member !== want.member) begin
					errors++;
					$error("is_member: expected %0d, got %0d", want.member, is_member);
				end
				if (rows_changed !== want.changed) begin
					errors++;
					$error("rows_changed: expected %0d, got %0d", want.changed, rows_changed);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		int phase;
		int n_items;
		logic [CFG_DATA_W-1:0] nc_data;
		logic [CFG_DATA_W-1:0] vc_data;
		arst_n = 1'b0;
		start = 1'b0;
		action = ACT_WRITE;
		row_node = '0;
		col_node = '0;
		distance = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		slot_setting = NEIGHBOUR_COUNT_RST;
		node_setting = NODE_COUNT_RST;
		gaps_on = 1'b1;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_register(CFG_SPARE_LO, 8'h00);
		write_register(CFG_SPARE_HI, 8'hFF);
		write_register(CFG_NEIGHBOUR_COUNT, 8'd2);
		write_register(CFG_NODE_COUNT, 8'd4);
		foreach (directed_steps[i])
			send_request(directed_steps[i].act, directed_steps[i].row, directed_steps[i].col,
				directed_steps[i].span, directed_steps[i].fixed, directed_steps[i].resp);

		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			gaps_on = (items_sent < ITEM_TARGET - QUIET_ITEMS) && ($urandom_range(0, 3) != 0);
			if (phase < 6) begin
				write_register(CFG_NEIGHBOUR_COUNT, PHASE_NC[phase]);
				write_register(CFG_NODE_COUNT, PHASE_VC[phase]);
			end else begin
				if ($urandom_range(0, 1)) begin
					case ($urandom_range(0, 5))
						0: nc_data = 8'h00;
						1: nc_data = 8'hFF;
						2: nc_data = {4'($urandom), 4'd9};
						default: nc_data = {4'($urandom), 4'($urandom_range(1, SLOTS))};
					endcase
					write_register(CFG_NEIGHBOUR_COUNT, nc_data);
				end
				if ($urandom_range(0, 1)) begin
					case ($urandom_range(0, 9))
						0: vc_data = {1'($urandom), 7'd0};
						1: vc_data = 8'd64;
						2: vc_data = 8'hFF;
						default: vc_data = {1'($urandom), 7'($urandom_range(1, 12))};
					endcase
					write_register(CFG_NODE_COUNT, vc_data);
				end
				if ($urandom_range(0, 7) == 0)
					write_register($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
						CFG_DATA_W'($urandom));
			end
			if ($urandom_range(0, 1))
				send_request(ACT_CLEAR, NODE_IN_W'($urandom), NODE_IN_W'($urandom),
					DIST_IN_W'($urandom), 1'b0, R_ZERO);
			n_items = (nodes_in_use() > 16) ? 20 : $urandom_range(30, 70);
			repeat (n_items) random_item();
			phase++;
		end

		@(negedge clk);
		start = 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
